// ----- design/krt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the keyed record table: field widths, command and status codes,
// the record type and the controller/datapath command and status structs.
// No dependencies.
package krt_pkg;

    localparam int KRT_DEPTH_DEFAULT = 128;

    localparam int CMD_W       = 1;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 8;
    localparam int AGE_W       = 7;
    localparam int PHONE_W     = 32;
    localparam int NAME_LOW_W  = 64;
    localparam int NAME_MID_W  = 64;
    localparam int NAME_HIGH_W = 32;
    localparam int STATUS_W    = 3;
    localparam int INDEX_W     = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic [AGE_W-1:0]          age;
        logic signed [PHONE_W-1:0] phone;
        logic [NAME_LOW_W-1:0]     name_low;
        logic [NAME_MID_W-1:0]     name_mid;
        logic [NAME_HIGH_W-1:0]    name_high;
    } t_rec;

    typedef struct packed {
        logic    load;
        logic    scan;
        logic    shift_init;
        logic    shift;
        logic    put;
        logic    result_load;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic full;
        logic is_search;
        logic shift_done;
    } t_dp_stat;

endpackage

// ----- design/krt_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the keyed record table: valid/ready plus one command.
// Depends on krt_pkg.
interface krt_req_if import krt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [KEY_W-1:0]   key;
    logic [POS_W-1:0]          position;
    logic [AGE_W-1:0]          age;
    logic signed [PHONE_W-1:0] phone;
    logic [NAME_LOW_W-1:0]     name_low;
    logic [NAME_MID_W-1:0]     name_mid;
    logic [NAME_HIGH_W-1:0]    name_high;

    modport source (output valid, cmd, key, position, age, phone, name_low, name_mid,
                    name_high, input ready);
    modport sink (input valid, cmd, key, position, age, phone, name_low, name_mid,
                  name_high, output ready);
endinterface

// ----- design/krt_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel of the keyed record table: valid/ready plus one result.
// Depends on krt_pkg.
interface krt_rsp_if import krt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [INDEX_W-1:0]        index;
    logic signed [KEY_W-1:0]   found_key;
    logic [AGE_W-1:0]          found_age;
    logic signed [PHONE_W-1:0] found_phone;
    logic [NAME_LOW_W-1:0]     found_name_low;
    logic [NAME_MID_W-1:0]     found_name_mid;
    logic [NAME_HIGH_W-1:0]    found_name_high;

    modport source (output valid, status, index, found_key, found_age, found_phone,
                    found_name_low, found_name_mid, found_name_high, input ready);
    modport sink (input valid, status, index, found_key, found_age, found_phone,
                  found_name_low, found_name_mid, found_name_high, output ready);
endinterface

// ----- design/krt_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the keyed record table: record memory, fill count, scan/shift
// address counter, read pipeline, hit capture and result register. Uses krt_pkg.
module krt_datapath import krt_pkg::*; #(
    parameter int TABLE_DEPTH = KRT_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_in_cmd,
    input  logic [POS_W-1:0]    i_in_position,
    input  t_rec                i_in_rec,
    output t_status             o_status,
    output logic [INDEX_W-1:0]  o_index,
    output t_rec                o_found_rec
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_rec                r_mem [TABLE_DEPTH];
    t_rec                r_rdata;
    t_rec                r_rec;
    t_rec                r_hit_rec;
    t_rec                r_out_rec;
    logic [CMD_W-1:0]    r_cmd;
    logic [POS_W-1:0]    r_pos;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_addr;
    logic [CW-1:0]       r_slot;
    logic [AW-1:0]       r_rd_idx;
    logic [AW-1:0]       r_hit_idx;
    logic                r_rd_vld;
    logic                r_hit;
    t_status             r_out_status;
    logic [INDEX_W-1:0]  r_out_index;

    logic                match;
    logic                scan_issue;
    logic                shift_issue;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       addr_m1;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_rec                wr_data;
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       fill_x;
    logic [XW-1:0]       pos_m1;
    logic [CW-1:0]       slot_c;
    logic [AW-1:0]       res_idx;
    logic [AW+INDEX_W-1:0] res_idx_wide;

    always_comb begin
        match       = r_rd_vld && (r_rdata.key == r_rec.key);
        scan_issue  = i_cmd.scan && !r_hit && !match && (r_addr < r_fill);
        shift_issue = i_cmd.shift && (r_addr > r_slot);
        addr_m1     = r_addr - CW'(1);
        rd_en       = scan_issue || shift_issue;
        rd_addr     = scan_issue ? r_addr[AW-1:0] : addr_m1[AW-1:0];
        wr_en       = (i_cmd.shift && r_rd_vld) || i_cmd.put;
        wr_addr     = i_cmd.put ? r_slot[AW-1:0] : (r_rd_idx + AW'(1));
        wr_data     = i_cmd.put ? r_rec : r_rdata;
    end

    // Position zero acts as one; a position past the fill count appends.
    always_comb begin
        pos_x  = XW'(r_pos);
        fill_x = XW'(r_fill);
        pos_m1 = pos_x - XW'(1);
        if (r_pos == '0) begin
            slot_c = '0;
        end else if (pos_x > fill_x) begin
            slot_c = r_fill;
        end else begin
            slot_c = pos_m1[CW-1:0];
        end
    end

    always_comb begin
        o_stat.scan_done  = r_hit || (!r_rd_vld && !(r_addr < r_fill));
        o_stat.hit        = r_hit;
        o_stat.full       = (r_fill == CW'(TABLE_DEPTH));
        o_stat.is_search  = (r_cmd == CMD_SEARCH);
        o_stat.shift_done = !r_rd_vld && !(r_addr > r_slot);
    end

    always_comb begin
        case (i_cmd.status)
            ST_FOUND:    res_idx = r_hit_idx;
            ST_INSERTED: res_idx = r_slot[AW-1:0];
            default:     res_idx = '0;
        endcase
        res_idx_wide = {{INDEX_W{1'b0}}, res_idx};
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hit    <= 1'b0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.shift_init) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan || i_cmd.shift) begin
                r_rd_vld <= rd_en;
            end
            if (i_cmd.scan && match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.put) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_cmd;
            r_pos  <= i_in_position;
            r_rec  <= i_in_rec;
            r_addr <= '0;
        end else if (i_cmd.shift_init) begin
            r_addr <= r_fill;
            r_slot <= slot_c;
        end else if (scan_issue) begin
            r_addr <= r_addr + CW'(1);
        end else if (shift_issue) begin
            r_addr <= addr_m1;
        end
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.scan && match) begin
            r_hit_idx <= r_rd_idx;
            r_hit_rec <= r_rdata;
        end
        if (i_cmd.result_load) begin
            r_out_status <= i_cmd.status;
            r_out_index  <= res_idx_wide[INDEX_W-1:0];
            r_out_rec    <= (i_cmd.status == ST_FOUND) ? r_hit_rec : '0;
        end
    end

    assign o_status    = r_out_status;
    assign o_index     = r_out_index;
    assign o_found_rec = r_out_rec;

endmodule

// ----- design/krt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the keyed record table: sequences scan, shift, write and
// result hand-off, and owns both channel handshakes. Uses krt_pkg.
module krt_ctrl import krt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_RESULT
    } t_state;

    t_state  r_state;
    t_status r_status;
    logic    r_out_valid;
    logic    out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE:   o_cmd.load = i_in_valid && i_rst_n;
            S_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.shift_init = i_stat.scan_done && !i_stat.is_search &&
                                   !i_stat.hit && !i_stat.full;
            end
            S_SHIFT:  o_cmd.shift = 1'b1;
            S_PUT:    o_cmd.put = 1'b1;
            S_RESULT: o_cmd.result_load = out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_done) begin
                        if (i_stat.is_search) begin
                            r_status <= i_stat.hit ? ST_FOUND : ST_NOT_FOUND;
                            r_state  <= S_RESULT;
                        end else if (i_stat.hit) begin
                            r_status <= ST_DUPLICATE;
                            r_state  <= S_RESULT;
                        end else if (i_stat.full) begin
                            r_status <= ST_FULL;
                            r_state  <= S_RESULT;
                        end else begin
                            r_status <= ST_INSERTED;
                            r_state  <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (i_stat.shift_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: r_state <= S_RESULT;
                S_RESULT: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stay closed while reset is held so no transaction is taken and dropped
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/keyed_record_table_top.sv -----
`timescale 1ns / 1ps
// Keyed record table: ordered table of records with unique keys, positional
// insert and search by key. Depends on krt_pkg, krt_req_if, krt_rsp_if,
// krt_ctrl and krt_datapath.
//
// Usage: i_req carries one transaction per command: insert (cmd 0) with key,
// 1-based position and record fields, or search (cmd 1) by key. o_rsp returns
// exactly one result per command: status, entry index and, on a hit, the
// stored record. Both channels transfer on valid and ready high at a clock edge.
// One command is worked at a time; i_req.ready is high only while idle.
// A search scans the filled entries through the single read port of the record
// memory, one key per cycle, and stops at the first hit. An insert scans the
// same way, then moves the entries from the insert slot upward one per cycle
// and writes the new record. A refused insert ends after the scan.
// The result sits in an output register, so the next command is accepted
// while it waits; if o_rsp stays stalled, the following result holds in the
// controller until the register frees.
// Reset (synchronous, active low) empties the table and drops any pending
// result; record storage is not cleared.
module keyed_record_table_top import krt_pkg::*; #(
    parameter int TABLE_DEPTH = KRT_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    krt_req_if.sink    i_req,
    krt_rsp_if.source  o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_rec     in_rec;
    t_rec     found_rec;
    t_status  out_status;

    always_comb begin
        in_rec.key       = i_req.key;
        in_rec.age       = i_req.age;
        in_rec.phone     = i_req.phone;
        in_rec.name_low  = i_req.name_low;
        in_rec.name_mid  = i_req.name_mid;
        in_rec.name_high = i_req.name_high;
    end

    krt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    krt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_cmd      (i_req.cmd),
        .i_in_position (i_req.position),
        .i_in_rec      (in_rec),
        .o_status      (out_status),
        .o_index       (o_rsp.index),
        .o_found_rec   (found_rec)
    );

    assign o_rsp.status          = out_status;
    assign o_rsp.found_key       = found_rec.key;
    assign o_rsp.found_age       = found_rec.age;
    assign o_rsp.found_phone     = found_rec.phone;
    assign o_rsp.found_name_low  = found_rec.name_low;
    assign o_rsp.found_name_mid  = found_rec.name_mid;
    assign o_rsp.found_name_high = found_rec.name_high;

endmodule

// ----- design/krt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the keyed record table and its bind to the top level.
// Depends on krt_pkg and keyed_record_table_top.
module krt_checker import krt_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [STATUS_W-1:0]     i_out_status,
    input logic [INDEX_W-1:0]      i_out_index,
    input logic signed [KEY_W-1:0] i_out_found_key
);

    // one command at a time: accepting closes the request side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted back to back");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_refused_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == ST_DUPLICATE || i_out_status == ST_FULL ||
                         i_out_status == ST_NOT_FOUND)) |-> (i_out_index == '0))
        else $error("nonzero index on a refused or missed command");

    a_record_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_FOUND) |-> (i_out_found_key == '0))
        else $error("record data without a hit");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_status) && $stable(i_out_index)))
        else $error("stalled result changed");

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_status    (o_rsp.status),
    .i_out_index     (o_rsp.index),
    .i_out_found_key (o_rsp.found_key)
);

// ----- bench/keyed_record_table_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for keyed_record_table_top: directed and random inserts and searches,
// checked against a table model kept in the bench. Depends on krt_pkg,
// krt_req_if, krt_rsp_if and the keyed_record_table_top RTL.
module keyed_record_table_top_tb;
    import krt_pkg::*;

    localparam int TABLE_DEPTH  = KRT_DEPTH_DEFAULT;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        t_rec             rec;
    } t_table_cmd;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
        t_rec               rec;
    } t_table_rsp;

    logic i_clk;
    logic i_rst_n;

    krt_req_if req_ch ();
    krt_rsp_if rsp_ch ();

    keyed_record_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Table model: filled entries in order, plus results still owed by the block
    t_rec       table_rows [TABLE_DEPTH];
    int         fill_cnt;
    t_table_rsp awaited_rsp[$];

    int err_cnt;
    int quiet_cycles;
    int stall_left;
    bit idle_on;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_table_rsp apply_to_table(t_table_cmd c);
        t_table_rsp r;
        int         hit;
        int         slot;
        int         p;
        r   = '0;
        hit = -1;
        for (int i = 0; i < fill_cnt; i++) begin
            if (hit < 0 && table_rows[i].key == c.rec.key) hit = i;
        end
        if (c.cmd == CMD_INSERT) begin
            if (hit >= 0) begin
                r.status = ST_DUPLICATE;
            end else if (fill_cnt >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                p = (c.position == '0) ? 1 : int'(c.position);
                if (p > fill_cnt) begin
                    slot = fill_cnt;
                end else begin
                    slot = p - 1;
                    for (int i = fill_cnt; i > slot; i--) table_rows[i] = table_rows[i-1];
                end
                table_rows[slot] = c.rec;
                fill_cnt++;
                r.status = ST_INSERTED;
                r.index  = slot[INDEX_W-1:0];
            end
        end else if (hit < 0) begin
            r.status = ST_NOT_FOUND;
        end else begin
            r.status = ST_FOUND;
            r.index  = hit[INDEX_W-1:0];
            r.rec    = table_rows[hit];
        end
        return r;
    endfunction

    function automatic t_rec random_record();
        t_rec rec;
        rec.key       = $urandom;
        rec.age       = AGE_W'($urandom_range(0, 127));
        rec.phone     = $urandom;
        rec.name_low  = {$urandom, $urandom};
        rec.name_mid  = {$urandom, $urandom};
        rec.name_high = $urandom;
        return rec;
    endfunction

    // All payload fields at zero or all at ones around the given key
    function automatic t_rec extreme_record(logic signed [KEY_W-1:0] key, bit ones);
        t_rec rec;
        rec     = ones ? '1 : '0;
        rec.key = key;
        return rec;
    endfunction

    function automatic logic signed [KEY_W-1:0] stored_key();
        return table_rows[$urandom_range(0, fill_cnt - 1)].key;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        err_cnt++;
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Drive one transaction, hold it until accepted, then record what it must return
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input t_rec rec);
        t_table_cmd c;
        c.cmd      = cmd;
        c.position = pos;
        c.rec      = rec;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        req_ch.cmd       = c.cmd;
        req_ch.key       = c.rec.key;
        req_ch.position  = c.position;
        req_ch.age       = c.rec.age;
        req_ch.phone     = c.rec.phone;
        req_ch.name_low  = c.rec.name_low;
        req_ch.name_mid  = c.rec.name_mid;
        req_ch.name_high = c.rec.name_high;
        req_ch.valid     = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        awaited_rsp.push_back(apply_to_table(c));
    endtask

    task automatic insert_rec(input logic [POS_W-1:0] pos, input t_rec rec);
        send_item(CMD_INSERT, pos, rec);
    endtask

    task automatic search_key(input logic signed [KEY_W-1:0] key);
        t_rec rec;
        rec     = random_record();
        rec.key = key;
        send_item(CMD_SEARCH, POS_W'($urandom), rec);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return POS_W'($urandom);
        return POS_W'($urandom_range(1, fill_cnt + 1));
    endfunction

    task automatic test_empty_table();
        search_key(32'sd0);
        search_key(32'sh8000_0000);
        insert_rec(8'd0, extreme_record(32'sh8000_0000, 1'b0));
    endtask

    task automatic test_insert_positions();
        t_rec rec;
        insert_rec(8'd255, extreme_record(32'sh7fff_ffff, 1'b1));
        rec = random_record(); rec.key = 32'sd0; insert_rec(8'd1, rec);
        rec = random_record(); rec.key = 32'sd1; insert_rec(8'd2, rec);
        // one past the fill count appends, the fill count itself shifts the last entry
        rec = random_record(); rec.key = 32'sd2; insert_rec(8'd5, rec);
        rec = random_record(); rec.key = 32'sd3; insert_rec(8'd5, rec);
        rec = random_record(); rec.key = 32'sd5; insert_rec(8'd3, rec);
    endtask

    task automatic test_duplicate_keys();
        t_rec rec;
        insert_rec(8'd1, extreme_record(32'sh7fff_ffff, 1'b0));
        rec = random_record(); rec.key = 32'sd0; insert_rec(8'd255, rec);
        insert_rec(8'd0, extreme_record(32'sh8000_0000, 1'b1));
    endtask

    task automatic test_search_hits();
        search_key(32'sh8000_0000);
        search_key(32'sh7fff_ffff);
        search_key(32'sd0);
        search_key(32'sd1);
        search_key(32'sd5);
        search_key(-32'sd1);
    endtask

    task automatic test_fill_table();
        int   r;
        t_rec rec;
        while (fill_cnt < TABLE_DEPTH) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                insert_rec(pick_position(), random_record());
            end else if (r < 15) begin
                search_key(stored_key());
            end else if (r < 17) begin
                search_key($urandom);
            end else begin
                rec     = random_record();
                rec.key = stored_key();
                insert_rec(pick_position(), rec);
            end
        end
    endtask

    task automatic test_full_table();
        t_rec rec;
        // duplicate wins over full
        rec     = random_record();
        rec.key = stored_key();
        insert_rec(8'd0, rec);
        insert_rec(8'd0, extreme_record(-32'sd1, 1'b1));
        insert_rec(8'd255, extreme_record(32'sh4000_0000, 1'b0));
        search_key(-32'sd1);
        search_key(32'sh7fff_ffff);
        search_key(32'sh8000_0000);
    endtask

    task automatic test_random_mix(input int count);
        int   r;
        t_rec rec;
        for (int n = 0; n < count; n++) begin
            // leave a quiet stretch now and then
            idle_on = (n % 250) < 200;
            r = $urandom_range(0, 19);
            if (r < 9) begin
                search_key(stored_key());
            end else if (r < 13) begin
                search_key($urandom);
            end else if (r < 17) begin
                insert_rec(POS_W'($urandom), random_record());
            end else begin
                rec     = random_record();
                rec.key = stored_key();
                insert_rec(POS_W'($urandom), rec);
            end
        end
    endtask

    task automatic test_random_mix_no_idle(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0) search_key(stored_key());
            else insert_rec(POS_W'($urandom), random_record());
        end
    endtask

    task automatic test_quiet_tail(input int count);
        idle_on = 1'b0;
        test_random_mix_no_idle(count);
    endtask

    // Result stall in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready = 1'b0;
        end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left   = $urandom_range(1, 6) - 1;
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_table_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0) begin
                flag_mismatch("unexpected result status", '0, 64'(rsp_ch.status));
            end else begin
                want = awaited_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
                if (rsp_ch.index !== want.index)
                    flag_mismatch("index", 64'(want.index), 64'(rsp_ch.index));
                if (rsp_ch.found_key !== want.rec.key)
                    flag_mismatch("found_key", 64'(unsigned'(want.rec.key)),
                                  64'(unsigned'(rsp_ch.found_key)));
                if (rsp_ch.found_age !== want.rec.age)
                    flag_mismatch("found_age", 64'(want.rec.age), 64'(rsp_ch.found_age));
                if (rsp_ch.found_phone !== want.rec.phone)
                    flag_mismatch("found_phone", 64'(unsigned'(want.rec.phone)),
                                  64'(unsigned'(rsp_ch.found_phone)));
                if (rsp_ch.found_name_low !== want.rec.name_low)
                    flag_mismatch("found_name_low", want.rec.name_low, rsp_ch.found_name_low);
                if (rsp_ch.found_name_mid !== want.rec.name_mid)
                    flag_mismatch("found_name_mid", want.rec.name_mid, rsp_ch.found_name_mid);
                if (rsp_ch.found_name_high !== want.rec.name_high)
                    flag_mismatch("found_name_high", 64'(want.rec.name_high),
                                  64'(rsp_ch.found_name_high));
            end
        end
    end

    // End the run if neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_INSERT;
        req_ch.key       = '0;
        req_ch.position  = '0;
        req_ch.age       = '0;
        req_ch.phone     = '0;
        req_ch.name_low  = '0;
        req_ch.name_mid  = '0;
        req_ch.name_high = '0;
        rsp_ch.ready     = 1'b0;
        fill_cnt         = 0;
        err_cnt          = 0;
        quiet_cycles     = 0;
        stall_left       = 0;
        idle_on          = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_insert_positions();
        test_duplicate_keys();
        test_search_hits();
        test_fill_table();
        test_full_table();
        test_random_mix(1350);
        test_quiet_tail(150);

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
design/krt_pkg.sv
design/krt_req_if.sv
design/krt_rsp_if.sv
design/krt_datapath.sv
design/krt_ctrl.sv
design/keyed_record_table_top.sv
design/krt_checker.sv
bench/keyed_record_table_top_tb.sv
